// ===== sv/stack_with_threshold_purge_defines.svh =====
// Assertion helpers for the stack block. Both expect clk and rst_n in scope.
`ifndef STACK_WITH_THRESHOLD_PURGE_DEFINES_SVH
`define STACK_WITH_THRESHOLD_PURGE_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define SWTP_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("stack assertion failed");

// Condition must hold in the cycle after the trigger.
`define SWTP_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("stack assertion failed");

`endif

// ===== sv/swtp_pkg.sv =====
package swtp_pkg;

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_POP   = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_PURGE = 3'd4;
  localparam logic [2:0] OP_DRAIN = 3'd5;

  localparam logic [1:0] ST_RECORD = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic [47:0]        tag;
    logic [7:0]         kind;
    logic signed [31:0] value;
  } record_t;

  typedef struct packed {
    logic [1:0] status;
    record_t    rec;
    logic       last;
  } result_t;

endpackage

// ===== sv/swtp_out_slot.sv =====
module swtp_out_slot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  swtp_pkg::result_t  res,
  output logic               free,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [47:0]        out_name_tag,
  output logic [7:0]         out_kind_code,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  logic              valid_r;
  logic              valid_nxt;
  swtp_pkg::result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = res_r.status;
  assign out_name_tag  = res_r.rec.tag;
  assign out_kind_code = res_r.rec.kind;
  assign out_value     = res_r.rec.value;
  assign out_last      = res_r.last;

endmodule

// ===== sv/stack_with_threshold_purge.sv =====
// Bounded LIFO stack of records (48-bit tag, kind byte, signed 32-bit value) kept in one
// synchronous record memory with a single read and a single write port. One operation is
// handled at a time and each result beat passes through an output register. Push, clear,
// unused codes and any operation on an empty stack finish in the idle state; pop and peek of
// a record first wait for the memory read. Purge reads the stack top-down to emit the removed
// records, then bottom-up to pack the kept ones, one memory read per cycle while no removed
// record waits for the result channel. Drain reads the stack top-down, emitting every record.
module stack_with_threshold_purge #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic [47:0]        in_name_tag,
  input  logic [7:0]         in_kind_code,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [47:0]        out_name_tag,
  output logic [7:0]         out_kind_code,
  output logic signed [31:0] out_value,
  output logic               out_last
);

`include "stack_with_threshold_purge_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_PRG  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DRN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      wp_r, wp_nxt;
  logic signed [31:0] limit_r, limit_nxt;
  logic               pop_r, pop_nxt;

  swtp_pkg::record_t  mem [DEPTH];
  swtp_pkg::record_t  rd_data_r;
  swtp_pkg::record_t  wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  swtp_pkg::result_t  res;
  logic               res_load;
  logic               out_free;

  logic [CW-1:0]      top_c;
  logic [AW-1:0]      top_a;
  logic               below;
  logic               in_fire;

  logic               out_no_record;
  logic               out_fields_zero;
  logic               push_ok;

  assign top_c    = cnt_r - CW'(1);
  assign top_a    = top_c[AW-1:0];
  assign below    = rd_data_r.value < limit_r;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    wp_nxt    = wp_r;
    limit_nxt = limit_r;
    pop_nxt   = pop_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = wp_r[AW-1:0];
    wr_data   = rd_data_r;
    res_load  = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            swtp_pkg::OP_PUSH: begin
              res_load = 1'b1;
              res.last = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                res.status = swtp_pkg::ST_FULL;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = cnt_r[AW-1:0];
                wr_data.tag   = in_name_tag;
                wr_data.kind  = in_kind_code;
                wr_data.value = in_item_value;
                cnt_nxt       = cnt_r + CW'(1);
                res.status    = swtp_pkg::ST_DONE;
              end
            end
            swtp_pkg::OP_POP, swtp_pkg::OP_PEEK: begin
              if (cnt_r == '0) begin
                res_load   = 1'b1;
                res.last   = 1'b1;
                res.status = swtp_pkg::ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = top_a;
                pop_nxt   = (in_operation == swtp_pkg::OP_POP);
                state_nxt = S_POP;
              end
            end
            swtp_pkg::OP_CLEAR: begin
              cnt_nxt    = '0;
              res_load   = 1'b1;
              res.last   = 1'b1;
              res.status = swtp_pkg::ST_DONE;
            end
            swtp_pkg::OP_PURGE, swtp_pkg::OP_DRAIN: begin
              limit_nxt = in_limit;
              if (cnt_r == '0) begin
                res_load   = 1'b1;
                res.last   = 1'b1;
                res.status = swtp_pkg::ST_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = top_a;
                idx_nxt   = top_a;
                state_nxt = (in_operation == swtp_pkg::OP_PURGE) ? S_PRG : S_DRN;
              end
            end
            default: begin
              res_load   = 1'b1;
              res.last   = 1'b1;
              res.status = swtp_pkg::ST_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.last   = 1'b1;
          res.status = swtp_pkg::ST_RECORD;
          res.rec    = rd_data_r;
          if (pop_r) begin
            cnt_nxt = top_c;
          end
          state_nxt = S_IDLE;
        end
      end
      S_PRG: begin
        // The read data stays put while a removed record waits for the output register.
        if (!below || out_free) begin
          if (below) begin
            res_load   = 1'b1;
            res.status = swtp_pkg::ST_RECORD;
            res.rec    = rd_data_r;
          end
          rd_en = 1'b1;
          if (idx_r == '0) begin
            rd_addr   = '0;
            wp_nxt    = '0;
            state_nxt = S_CMP;
          end else begin
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end
      end
      S_CMP: begin
        // Kept records slide down; the write pointer never passes the read index.
        if (!below) begin
          wr_en   = 1'b1;
          wr_addr = wp_r[AW-1:0];
          wr_data = rd_data_r;
        end
        if (CW'(idx_r) == top_c) begin
          cnt_nxt   = wp_r + CW'(!below);
          state_nxt = S_FIN;
        end else begin
          wp_nxt  = wp_r + CW'(!below);
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DRN: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.status = swtp_pkg::ST_RECORD;
          res.rec    = rd_data_r;
          if (idx_r == '0) begin
            cnt_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.last   = 1'b1;
          res.status = swtp_pkg::ST_DONE;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    wp_r    <= wp_nxt;
    limit_r <= limit_nxt;
    pop_r   <= pop_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  swtp_out_slot u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (res_load),
    .res           (res),
    .free          (out_free),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_name_tag  (out_name_tag),
    .out_kind_code (out_kind_code),
    .out_value     (out_value),
    .out_last      (out_last)
  );

  assign out_no_record   = out_valid && (out_status != swtp_pkg::ST_RECORD);
  assign out_fields_zero = (out_name_tag == 48'd0) && (out_kind_code == 8'd0) &&
                           (out_value == 32'sd0);
  assign push_ok         = in_fire && (in_operation == swtp_pkg::OP_PUSH) &&
                           (cnt_r != CW'(DEPTH));

  `SWTP_ASSERT_NOW(a_load_when_free, res_load, out_free)
  `SWTP_ASSERT_NOW(a_count_range, 1'b1, cnt_r <= CW'(DEPTH))
  `SWTP_ASSERT_NOW(a_status_zero_fields, out_no_record, out_fields_zero)
  `SWTP_ASSERT_NEXT(a_push_grows, push_ok, cnt_r == $past(cnt_r) + CW'(1))

endmodule
